### hdl/etfd_pkg.sv
`timescale 1ns / 1ps

package etfd_pkg;

  // request opcodes
  localparam logic [2:0] OP_CAR  = 3'd0;
  localparam logic [2:0] OP_UPC  = 3'd1;
  localparam logic [2:0] OP_DNC  = 3'd2;
  localparam logic [2:0] OP_IDLE = 3'd3;
  localparam logic [2:0] OP_MVUP = 3'd4;
  localparam logic [2:0] OP_MVDN = 3'd5;
  localparam logic [2:0] OP_HOME = 3'd6;

  // car level is floors with 8 fraction bits
  localparam int          LEVEL_W   = 12;
  localparam int          FRAC_W    = 8;
  localparam logic [7:0]  HALF      = 8'd128;
  localparam logic [7:0]  TOL_RESET = 8'd13;

  typedef struct packed {
    logic busy;
    logic done;
  } scan_stat_t;

endpackage

### hdl/elevator_target_floor_dispatch_top.sv
`timescale 1ns / 1ps
// sequencing: light, moving and home requests pass from EXEC to DONE and into the output reg,
//   an idle pick runs the scan between EXEC and DONE (one floor per cycle through the shared scan compare)
// throughput: one request at a time; next request taken once the previous is in the output reg
// reset: synchronous active-low rst_n clears all lights, target 0, direction up,
//   floor tolerance 13, and empties the output register

module elevator_target_floor_dispatch_top
  import etfd_pkg::*;
#(
  parameter int FLOORS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [3:0]  in_floor_number,
  input  logic        in_light_on,
  input  logic [11:0] in_car_level,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_target_floor,
  output logic        out_going_up,
  // floor tolerance register
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int IW = $clog2(FLOORS);
  localparam int FW = $clog2(FLOORS + 1);
  localparam int CW = (FW > 5) ? FW : 5;
  localparam logic [CW-1:0] FLOORS_C = CW'(FLOORS);
  localparam logic [CW-1:0] ONE_C    = CW'(1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state_r, state_nxt;
  // captured request
  logic [2:0]         op_r;
  logic [3:0]         fl_r;
  logic               on_r;
  logic [LEVEL_W-1:0] level_r;
  // architectural state
  logic [7:0]         tol_r;
  logic [FLOORS-1:0]  car_r, car_nxt, up_r, up_nxt, dn_r, dn_nxt;
  logic               dir_r, dir_nxt;
  logic [FW-1:0]      tgt_r, tgt_nxt;
  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [3:0]         out_tgt_r, out_tgt_nxt;
  logic               out_up_r, out_up_nxt;

  // fixed point decode of the car level
  logic [CW-1:0]       ip_c, nearest_c, fl_c, tgt_c, ip1_c;
  logic [FRAC_W-1:0]   frac;
  logic [LEVEL_W:0]    level_rnd;
  logic                at_floor, fl_ok;
  logic [IW-1:0]       fl_idx, up_idx, dn_idx;

  // scan unit
  logic               scan_start;
  scan_stat_t         scan_stat;
  logic [FW-1:0]      above_cu, above_dn, below_cd, below_up;
  logic [FW-1:0]      res_up, res_dn;

  etfd_scan #(
    .FLOORS(FLOORS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (scan_start),
    .nearest    (nearest_c),
    .car_lights (car_r),
    .up_lights  (up_r),
    .dn_lights  (dn_r),
    .stat       (scan_stat),
    .above_cu   (above_cu),
    .above_dn   (above_dn),
    .below_cd   (below_cd),
    .below_up   (below_up)
  );

  always_comb begin
    ip_c      = CW'(level_r[LEVEL_W-1:FRAC_W]);
    ip1_c     = ip_c + ONE_C;
    frac      = level_r[FRAC_W-1:0];
    // half a floor rounds up to the next one
    level_rnd = {1'b0, level_r} + (LEVEL_W+1)'(HALF);
    nearest_c = CW'(level_rnd[LEVEL_W:FRAC_W]);
    at_floor  = frac < tol_r;
    fl_c      = CW'(fl_r);
    fl_ok     = (fl_c >= ONE_C) && (fl_c <= FLOORS_C);
    fl_idx    = IW'(fl_c - ONE_C);
    up_idx    = IW'(ip_c);
    dn_idx    = IW'(ip_c - ONE_C);
    tgt_c     = CW'(tgt_r);
    // scan outcome per direction: preferred lights first, then the opposite calls
    res_up    = (above_cu != '0) ? above_cu : above_dn;
    res_dn    = (below_cd != '0) ? below_cd : below_up;
  end

  // sequencer and state update
  always_comb begin
    state_nxt     = state_r;
    car_nxt       = car_r;
    up_nxt        = up_r;
    dn_nxt        = dn_r;
    dir_nxt       = dir_r;
    tgt_nxt       = tgt_r;
    scan_start    = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_tgt_nxt   = out_tgt_r;
    out_up_nxt    = out_up_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_CAR: begin
            if (fl_ok) car_nxt[fl_idx] = on_r;
          end
          OP_UPC: begin
            if (fl_ok) up_nxt[fl_idx] = on_r;
          end
          OP_DNC: begin
            if (fl_ok) dn_nxt[fl_idx] = on_r;
          end
          OP_IDLE: begin
            // direction forced at the end floors, then the scan runs
            if (nearest_c == ONE_C) dir_nxt = 1'b1;
            else if (nearest_c == FLOORS_C) dir_nxt = 1'b0;
            scan_start = 1'b1;
            state_nxt  = S_SCAN;
          end
          OP_MVUP: begin
            // stop at the next floor up if someone wants it; top floor keeps target
            if (!(at_floor && tgt_c == ip_c) && tgt_c != ip1_c && frac <= HALF &&
                ip1_c <= FLOORS_C &&
                (car_r[up_idx] || up_r[up_idx] || (tgt_c < ip1_c && dn_r[up_idx])))
              tgt_nxt = FW'(ip1_c);
          end
          OP_MVDN: begin
            if (at_floor && ip_c == ONE_C) begin
              tgt_nxt = FW'(1);
            end else if (tgt_c != ip_c && frac >= HALF && ip_c >= ONE_C &&
                         ip_c <= FLOORS_C &&
                         (car_r[dn_idx] || dn_r[dn_idx] || (tgt_c >= ip_c && up_r[dn_idx]))) begin
              tgt_nxt = FW'(ip_c);
            end
          end
          OP_HOME: begin
            car_nxt = '0;
            up_nxt  = '0;
            dn_nxt  = '0;
            dir_nxt = 1'b0;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          state_nxt = S_DONE;
          // keep direction if anything lies ahead, else reverse when the other side has one
          if (dir_r) begin
            if (res_up != '0) begin
              tgt_nxt = res_up;
            end else begin
              tgt_nxt = res_dn;
              if (res_dn != '0) dir_nxt = 1'b0;
            end
          end else begin
            if (res_dn != '0) begin
              tgt_nxt = res_dn;
            end else begin
              tgt_nxt = res_up;
              if (res_up != '0) dir_nxt = 1'b1;
            end
          end
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_tgt_nxt   = 4'(tgt_r);
          out_up_nxt    = dir_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      car_r       <= '0;
      up_r        <= '0;
      dn_r        <= '0;
      dir_r       <= 1'b1;
      tgt_r       <= '0;
      tol_r       <= TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      car_r       <= car_nxt;
      up_r        <= up_nxt;
      dn_r        <= dn_nxt;
      dir_r       <= dir_nxt;
      tgt_r       <= tgt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) tol_r <= cfg_wdata;
    end
  end

  // request capture and output payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r    <= in_opcode;
      fl_r    <= in_floor_number;
      on_r    <= in_light_on;
      level_r <= in_car_level;
    end
    out_tgt_r <= out_tgt_nxt;
    out_up_r  <= out_up_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_target_floor = out_tgt_r;
  assign out_going_up     = out_up_r;

endmodule

### hdl/etfd_scan.sv
`timescale 1ns / 1ps

module etfd_scan
  import etfd_pkg::*;
#(
  parameter int FLOORS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [((($clog2(FLOORS+1)) > 5) ? $clog2(FLOORS+1) : 5)-1:0] nearest,
  input  logic [FLOORS-1:0]                car_lights,
  input  logic [FLOORS-1:0]                up_lights,
  input  logic [FLOORS-1:0]                dn_lights,
  output scan_stat_t                       stat,
  output logic [$clog2(FLOORS+1)-1:0]      above_cu,
  output logic [$clog2(FLOORS+1)-1:0]      above_dn,
  output logic [$clog2(FLOORS+1)-1:0]      below_cd,
  output logic [$clog2(FLOORS+1)-1:0]      below_up
);

  localparam int IW = $clog2(FLOORS);
  localparam int FW = $clog2(FLOORS + 1);
  localparam int CW = (FW > 5) ? FW : 5;
  localparam logic [IW-1:0] LAST = IW'(FLOORS - 1);

  logic [IW-1:0] idx_r, idx_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [FW-1:0] acu_r, acu_nxt, adn_r, adn_nxt, bcd_r, bcd_nxt, bup_r, bup_nxt;
  logic [FW-1:0] flr;
  logic [CW-1:0] flr_c;
  logic          is_above, is_below;

  // one floor per cycle through the shared compare against the nearest floor
  always_comb begin
    flr      = FW'(idx_r) + FW'(1);
    flr_c    = CW'(flr);
    is_above = flr_c > nearest;
    is_below = flr_c < nearest;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    acu_nxt  = acu_r;
    adn_nxt  = adn_r;
    bcd_nxt  = bcd_r;
    bup_nxt  = bup_r;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      acu_nxt  = '0;
      adn_nxt  = '0;
      bcd_nxt  = '0;
      bup_nxt  = '0;
    end else if (busy_r) begin
      // lowest hit above, highest hit below
      if (is_above && (car_lights[idx_r] || up_lights[idx_r]) && acu_r == '0) acu_nxt = flr;
      if (is_above && dn_lights[idx_r] && adn_r == '0) adn_nxt = flr;
      if (is_below && (car_lights[idx_r] || dn_lights[idx_r])) bcd_nxt = flr;
      if (is_below && up_lights[idx_r]) bup_nxt = flr;
      if (idx_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    acu_r <= acu_nxt;
    adn_r <= adn_nxt;
    bcd_r <= bcd_nxt;
    bup_r <= bup_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign above_cu  = acu_r;
  assign above_dn  = adn_r;
  assign below_cd  = bcd_r;
  assign below_up  = bup_r;

endmodule
